### rtl/kwms_pkg.sv
// kwms_pkg: field widths, operation and status codes, default sizes
// for the k-way merge unit. No dependencies.
package kwms_pkg;

  localparam int KEY_W     = 31;
  localparam int TAG_W     = 16;
  localparam int OP_W      = 2;
  localparam int RUN_IDX_W = 3;
  localparam int STATUS_W  = 3;
  localparam int CFG_W     = 4;

  localparam int RUNS_DEF  = 8;
  localparam int DEPTH_DEF = 1024;

  localparam logic [CFG_W-1:0] RUNS_IN_USE_RESET = 4'd8;

  localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OP_W-1:0] OP_POP    = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED = 3'd0;
  localparam logic [STATUS_W-1:0] ST_POPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_RUN  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd5;

endpackage

### rtl/kwms_ram.sv
// kwms_ram: generic single-write, single-read synchronous RAM with a
// registered read port. No dependencies.
module kwms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/kway_merge_min_select_unit.sv
// Append and clear: the result passes through S_DONE into the output register; the next item is taken after that.
// Pop: the run heads are read from entry memory one run per cycle through the
// registered read port, then the result passes through S_DONE to the output.
// The result sits in an output register, so a new item is taken while it waits.
// Synchronous active-high reset: runs empty, runs_in_use = 8, no result pending.
// Entry memory is not cleared; only entries written since a clear are read.
module kway_merge_min_select_unit #(
  parameter int RUNS  = kwms_pkg::RUNS_DEF,
  parameter int DEPTH = kwms_pkg::DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kwms_pkg::OP_W-1:0]      operation,
  input  logic [kwms_pkg::RUN_IDX_W-1:0] run_index,
  input  logic [kwms_pkg::KEY_W-1:0]     entry_key,
  input  logic [kwms_pkg::TAG_W-1:0]     entry_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kwms_pkg::STATUS_W-1:0]  status,
  output logic [kwms_pkg::KEY_W-1:0]     popped_key,
  output logic [kwms_pkg::TAG_W-1:0]     popped_tag,
  output logic [kwms_pkg::RUN_IDX_W-1:0] popped_run,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kwms_pkg::CFG_W-1:0]     cfg_data
);

  localparam int RUNW = $clog2(RUNS);
  localparam int POSW = $clog2(DEPTH);
  localparam int CNTW = POSW + 1;
  localparam int SCW  = $clog2(RUNS + 1);
  localparam int KW   = kwms_pkg::KEY_W;
  localparam int TW   = kwms_pkg::TAG_W;
  localparam int ENTW = KW + TW;
  localparam int AW   = RUNW + POSW;
  localparam int MEMD = 2 ** AW;

  localparam logic [7:0]      RUNS8     = 8'(RUNS);
  localparam logic [CNTW-1:0] DEPTH_CNT = CNTW'(DEPTH);
  localparam logic [POSW-1:0] POS_LAST  = POSW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]                 state;
  logic [kwms_pkg::CFG_W-1:0] runs_cfg;
  logic [POSW-1:0]            run_head     [RUNS];
  logic [CNTW-1:0]            run_count    [RUNS];
  logic [KW-1:0]              run_last_key [RUNS];

  logic [SCW-1:0]  scan;
  logic            pend;
  logic [RUNW-1:0] pend_run;
  logic            found;
  logic [RUNW-1:0] best_run;
  logic [KW-1:0]   best_key;
  logic [TW-1:0]   best_tag;

  logic [kwms_pkg::STATUS_W-1:0]  res_status;
  logic [KW-1:0]                  res_key;
  logic [TW-1:0]                  res_tag;
  logic [kwms_pkg::RUN_IDX_W-1:0] res_run;

  logic [7:0]      cfg_ext;
  logic [7:0]      n_ext;
  logic [SCW-1:0]  n_eff;
  logic [7:0]      ri_ext;
  logic [RUNW-1:0] sel_ri;
  logic            scan_lt_n;
  logic [RUNW-1:0] sel_run;
  logic [POSW-1:0] head_sel;
  logic [CNTW-1:0] count_sel;
  logic [KW-1:0]   last_sel;
  logic [POSW:0]   tail_sum;
  logic [POSW-1:0] tail_pos;
  logic [POSW-1:0] head_inc;
  logic            bad_run;
  logic            run_full;
  logic            out_of_order;
  logic            append_ok;
  logic [7:0]      best_ext;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ENTW-1:0] ram_wdata;
  logic            ram_re;
  logic [AW-1:0]   ram_raddr;
  logic [ENTW-1:0] ram_rdata;
  logic [KW-1:0]   rd_key;
  logic [TW-1:0]   rd_tag;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_ext = 8'(runs_cfg);
    if (cfg_ext == 8'd0) begin
      n_ext = 8'd1;
    end else if (cfg_ext > RUNS8) begin
      n_ext = RUNS8;
    end else begin
      n_ext = cfg_ext;
    end
  end

  assign n_eff     = n_ext[SCW-1:0];
  assign ri_ext    = 8'(run_index);
  assign sel_ri    = ri_ext[RUNW-1:0];
  assign scan_lt_n = (scan < n_eff);

  always_comb begin
    case (state)
      S_IDLE:  sel_run = sel_ri;
      S_SCAN:  sel_run = scan_lt_n ? scan[RUNW-1:0] : best_run;
      default: sel_run = best_run;
    endcase
  end

  assign head_sel  = run_head[sel_run];
  assign count_sel = run_count[sel_run];
  assign last_sel  = run_last_key[sel_run];

  assign tail_sum = {1'b0, head_sel} + count_sel;
  assign tail_pos = (tail_sum >= DEPTH_CNT) ? POSW'(tail_sum - DEPTH_CNT) : tail_sum[POSW-1:0];
  assign head_inc = (head_sel == POS_LAST) ? '0 : head_sel + 1'b1;

  assign bad_run      = (ri_ext >= n_ext);
  assign run_full     = (count_sel >= DEPTH_CNT);
  assign out_of_order = (count_sel != '0) && (entry_key < last_sel);
  assign append_ok    = !bad_run && !run_full && !out_of_order;

  assign ram_we    = in_valid && in_ready && (operation == kwms_pkg::OP_APPEND) && append_ok;
  assign ram_waddr = {sel_ri, tail_pos};
  assign ram_wdata = {entry_key, entry_tag};
  assign ram_re    = (state == S_SCAN) && scan_lt_n;
  assign ram_raddr = {scan[RUNW-1:0], head_sel};
  assign rd_key    = ram_rdata[ENTW-1:TW];
  assign rd_tag    = ram_rdata[TW-1:0];
  assign best_ext  = 8'(best_run);

  kwms_ram #(
    .WIDTH (ENTW),
    .DEPTH (MEMD)
  ) u_entries (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      runs_cfg  <= kwms_pkg::RUNS_IN_USE_RESET;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      found     <= 1'b0;
      for (int i = 0; i < RUNS; i++) begin
        run_head[i]     <= '0;
        run_count[i]    <= '0;
        run_last_key[i] <= '0;
      end
    end else begin
      if (cfg_valid) begin
        runs_cfg <= cfg_data;
      end
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            res_key <= '0;
            res_tag <= '0;
            res_run <= '0;
            case (operation)
              kwms_pkg::OP_APPEND: begin
                if (bad_run) begin
                  res_status <= kwms_pkg::ST_BAD_RUN;
                end else if (run_full) begin
                  res_status <= kwms_pkg::ST_FULL;
                end else if (out_of_order) begin
                  res_status <= kwms_pkg::ST_ORDER;
                end else begin
                  res_status            <= kwms_pkg::ST_ACCEPTED;
                  run_count[sel_run]    <= count_sel + 1'b1;
                  run_last_key[sel_run] <= entry_key;
                end
                state <= S_DONE;
              end
              kwms_pkg::OP_POP: begin
                scan  <= '0;
                pend  <= 1'b0;
                found <= 1'b0;
                state <= S_SCAN;
              end
              kwms_pkg::OP_CLEAR: begin
                for (int i = 0; i < RUNS; i++) begin
                  run_head[i]     <= '0;
                  run_count[i]    <= '0;
                  run_last_key[i] <= '0;
                end
                res_status <= kwms_pkg::ST_ACCEPTED;
                state      <= S_DONE;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // strict compare keeps the lowest run on equal keys
          if (pend && (!found || (rd_key < best_key))) begin
            found    <= 1'b1;
            best_run <= pend_run;
            best_key <= rd_key;
            best_tag <= rd_tag;
          end
          if (scan_lt_n) begin
            pend     <= (count_sel != '0);
            pend_run <= sel_run;
            scan     <= scan + 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              if (found) begin
                run_head[sel_run]  <= head_inc;
                run_count[sel_run] <= count_sel - 1'b1;
                res_status <= kwms_pkg::ST_POPPED;
                res_key    <= best_key;
                res_tag    <= best_tag;
                res_run    <= best_ext[kwms_pkg::RUN_IDX_W-1:0];
              end else begin
                res_status <= kwms_pkg::ST_EMPTY;
              end
              state <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            status     <= res_status;
            popped_key <= res_key;
            popped_tag <= res_tag;
            popped_run <= res_run;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/kwms_checker.sv
// kwms_checker: port-level assertions for the k-way merge unit, bound to
// the top level. Depends on kwms_pkg.
module kwms_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic [kwms_pkg::OP_W-1:0]      operation,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [kwms_pkg::STATUS_W-1:0]  status,
  input logic [kwms_pkg::KEY_W-1:0]     popped_key,
  input logic [kwms_pkg::TAG_W-1:0]     popped_tag,
  input logic [kwms_pkg::RUN_IDX_W-1:0] popped_run
);

  // nothing pending straight after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // popped fields are zero unless the result is a pop
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != kwms_pkg::ST_POPPED)) |->
      ((popped_key == '0) && (popped_tag == '0) && (popped_run == '0)))
    else $error("popped fields not zero on a non-pop result");

  // any transfer that yields a result keeps the input closed next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && ((operation == kwms_pkg::OP_APPEND) ||
      (operation == kwms_pkg::OP_POP) || (operation == kwms_pkg::OP_CLEAR))) |=> !in_ready)
    else $error("input taken while an item is still in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(status) && $stable(popped_key) && $stable(popped_tag)))
    else $error("stalled result changed");

endmodule

bind kway_merge_min_select_unit kwms_checker u_kwms_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .operation  (operation),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .status     (status),
  .popped_key (popped_key),
  .popped_tag (popped_tag),
  .popped_run (popped_run)
);

### test/kway_merge_min_select_unit_test.sv
// Self-checking bench for kway_merge_min_select_unit: directed table, then randomised
// runs of appends, pops, clears and unused ops under several runs_in_use settings.
// Depends on kwms_pkg and the unit itself; a local merge predictor supplies expectations.
module kway_merge_min_select_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KEY_W     = kwms_pkg::KEY_W;
  localparam int TAG_W     = kwms_pkg::TAG_W;
  localparam int OP_W      = kwms_pkg::OP_W;
  localparam int RUN_IDX_W = kwms_pkg::RUN_IDX_W;
  localparam int STATUS_W  = kwms_pkg::STATUS_W;
  localparam int CFG_W     = kwms_pkg::CFG_W;

  localparam logic [CFG_W-1:0]    RUNS_IN_USE_RESET = kwms_pkg::RUNS_IN_USE_RESET;
  localparam logic [OP_W-1:0]     OP_APPEND   = kwms_pkg::OP_APPEND;
  localparam logic [OP_W-1:0]     OP_POP      = kwms_pkg::OP_POP;
  localparam logic [OP_W-1:0]     OP_CLEAR    = kwms_pkg::OP_CLEAR;
  localparam logic [STATUS_W-1:0] ST_ACCEPTED = kwms_pkg::ST_ACCEPTED;
  localparam logic [STATUS_W-1:0] ST_POPPED   = kwms_pkg::ST_POPPED;
  localparam logic [STATUS_W-1:0] ST_FULL     = kwms_pkg::ST_FULL;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = kwms_pkg::ST_EMPTY;
  localparam logic [STATUS_W-1:0] ST_BAD_RUN  = kwms_pkg::ST_BAD_RUN;
  localparam logic [STATUS_W-1:0] ST_ORDER    = kwms_pkg::ST_ORDER;

  localparam int RUNS         = kwms_pkg::RUNS_DEF;
  localparam int DEPTH        = kwms_pkg::DEPTH_DEF;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic [KEY_W-1:0] KEY_MAX   = '1;
  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [RUN_IDX_W-1:0] ri;
    logic [KEY_W-1:0]     key;
    logic [TAG_W-1:0]     tag;
  } merge_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [KEY_W-1:0]     key;
    logic [TAG_W-1:0]     tag;
    logic [RUN_IDX_W-1:0] run;
  } merge_result_t;

  typedef struct {
    merge_item_t   item;
    bit            typed;
    merge_result_t want;
  } stim_entry_t;

  typedef enum bit {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_W-1:0]     cfg;
    logic [OP_W-1:0]      op;
    logic [RUN_IDX_W-1:0] ri;
    logic [KEY_W-1:0]     key;
    logic [TAG_W-1:0]     tag;
    bit                   typed;
    logic [STATUS_W-1:0]  st;
    logic [KEY_W-1:0]     pk;
    logic [TAG_W-1:0]     pt;
    logic [RUN_IDX_W-1:0] pr;
  } dir_row_t;

  dir_row_t dir_table [29] = '{
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_EMPTY,    0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 0, 5,       'hAAAA, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 0, 4,       'h0001, 1, ST_ORDER,    0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 0, 5,       'h5555, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 1, 0,       'h0000, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 7, KEY_MAX, 'hFFFF, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 2, 5,       'h1234, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_POPPED,   0,       'h0000, 1},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_POPPED,   5,       'hAAAA, 0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_POPPED,   KEY_MAX, 'hFFFF, 7},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_EMPTY,    0,       0,      0},
    '{ROW_ITEM, 0,  OP_UNUSED, 5, KEY_MAX, 'hFFFF, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 3, 100,     'h00C3, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_CLEAR,  0, 0,       'h0000, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_EMPTY,    0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 3, 1,       'hBEEF, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_CFG,  3,  OP_POP,    0, 0,       'h0000, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 3, 9,       'h0009, 1, ST_BAD_RUN,  0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 7, 9,       'h0009, 1, ST_BAD_RUN,  0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_EMPTY,    0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 2, 50,      'h0007, 1, ST_ACCEPTED, 0,       0,      0},
    '{ROW_CFG,  0,  OP_POP,    0, 0,       'h0000, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_EMPTY,    0,       0,      0},
    '{ROW_ITEM, 0,  OP_APPEND, 1, 3,       'h0003, 1, ST_BAD_RUN,  0,       0,      0},
    '{ROW_CFG,  15, OP_POP,    0, 0,       'h0000, 0, ST_ACCEPTED, 0,       0,      0},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 1, ST_POPPED,   1,       'hBEEF, 3},
    '{ROW_ITEM, 0,  OP_POP,    0, 0,       'h0000, 0, ST_ACCEPTED, 0,       0,      0}
  };

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [OP_W-1:0]      operation = '0;
  logic [RUN_IDX_W-1:0] run_index = '0;
  logic [KEY_W-1:0]     entry_key = '0;
  logic [TAG_W-1:0]     entry_tag = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [KEY_W-1:0]     popped_key;
  logic [TAG_W-1:0]     popped_tag;
  logic [RUN_IDX_W-1:0] popped_run;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;

  kway_merge_min_select_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .operation  (operation),
    .run_index  (run_index),
    .entry_key  (entry_key),
    .entry_tag  (entry_tag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .popped_key (popped_key),
    .popped_tag (popped_tag),
    .popped_run (popped_run),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [KEY_W-1:0] ring_keys [RUNS][DEPTH];
  logic [TAG_W-1:0] ring_tags [RUNS][DEPTH];
  int unsigned      ring_head [RUNS] = '{default: 0};
  int unsigned      ring_fill [RUNS] = '{default: 0};
  logic [KEY_W-1:0] ring_last_key [RUNS] = '{default: '0};
  logic [CFG_W-1:0] runs_setting = RUNS_IN_USE_RESET;

  // generator's lower bound for the next in-order key of each run
  logic [KEY_W-1:0] run_key_floor [RUNS] = '{default: '0};

  stim_entry_t   queued_ops [$];
  stim_entry_t   on_bus;
  merge_result_t pending_results [$];
  int unsigned   items_queued = 0;
  int unsigned   items_taken = 0;
  int unsigned   error_count = 0;
  int unsigned   cycle_count = 0;
  int unsigned   in_gap = 0;
  int unsigned   out_stall = 0;
  bit            in_calm = 1'b0;
  bit            out_calm = 1'b0;

  function automatic bit merge_outcome(input merge_item_t it, output merge_result_t res);
    int unsigned      live;
    int unsigned      slot;
    int unsigned      best;
    bit               found;
    logic [KEY_W-1:0] best_key;
    res = '0;
    live = (runs_setting == 0) ? 1 : (runs_setting > RUNS) ? RUNS : runs_setting;
    case (it.op)
      OP_APPEND: begin
        if (it.ri >= live) begin
          res.status = ST_BAD_RUN;
        end else if (ring_fill[it.ri] >= DEPTH) begin
          res.status = ST_FULL;
        end else if (ring_fill[it.ri] != 0 && it.key < ring_last_key[it.ri]) begin
          res.status = ST_ORDER;
        end else begin
          slot = (ring_head[it.ri] + ring_fill[it.ri]) % DEPTH;
          ring_keys[it.ri][slot] = it.key;
          ring_tags[it.ri][slot] = it.tag;
          ring_fill[it.ri]++;
          ring_last_key[it.ri] = it.key;
          res.status = ST_ACCEPTED;
        end
      end
      OP_POP: begin
        found = 1'b0;
        best = 0;
        best_key = '0;
        for (int r = 0; r < live; r++) begin
          if (ring_fill[r] != 0 && (!found || ring_keys[r][ring_head[r]] < best_key)) begin
            found = 1'b1;
            best = r;
            best_key = ring_keys[r][ring_head[r]];
          end
        end
        if (!found) begin
          res.status = ST_EMPTY;
        end else begin
          res.status = ST_POPPED;
          res.key = best_key;
          res.tag = ring_tags[best][ring_head[best]];
          res.run = RUN_IDX_W'(best);
          ring_head[best] = (ring_head[best] + 1) % DEPTH;
          ring_fill[best]--;
        end
      end
      OP_CLEAR: begin
        foreach (ring_head[r]) begin
          ring_head[r] = 0;
          ring_fill[r] = 0;
          ring_last_key[r] = '0;
        end
        res.status = ST_ACCEPTED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // input side: predict on each transfer, then present the next op after a drawn gap
  always @(posedge clk) begin
    merge_result_t outcome;
    stim_entry_t   nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        items_taken++;
        if (merge_outcome(on_bus.item, outcome))
          pending_results.push_back(on_bus.typed ? on_bus.want : outcome);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_gap <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (queued_ops.size() != 0) begin
          nxt = queued_ops.pop_front();
          on_bus <= nxt;
          operation <= nxt.item.op;
          run_index <= nxt.item.ri;
          entry_key <= nxt.item.key;
          entry_tag <= nxt.item.tag;
          in_valid <= 1'b1;
          if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
          in_gap <= in_calm ? 0 : $urandom_range(0, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: check against the oldest expectation, then stall for a drawn count
  always @(posedge clk) begin
    merge_result_t want;
    int unsigned   stall_draw;
    if (rst) begin
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending, status %0d", status));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", status, want.status));
        if (popped_key !== want.key)
          report_mismatch($sformatf("popped_key %0h, want %0h", popped_key, want.key));
        if (popped_tag !== want.tag)
          report_mismatch($sformatf("popped_tag %0h, want %0h", popped_tag, want.tag));
        if (popped_run !== want.run)
          report_mismatch($sformatf("popped_run %0d, want %0d", popped_run, want.run));
      end
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      stall_draw = out_calm ? 0 : $urandom_range(0, 3);
      out_stall <= stall_draw;
      out_ready <= (stall_draw == 0);
    end else if (out_stall != 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic queue_op(input logic [OP_W-1:0] op, input logic [RUN_IDX_W-1:0] ri,
                          input logic [KEY_W-1:0] k, input logic [TAG_W-1:0] t,
                          input bit typed = 1'b0, input merge_result_t want = '0);
    stim_entry_t e;
    e.item = '{op: op, ri: ri, key: k, tag: t};
    e.typed = typed;
    e.want = want;
    queued_ops.push_back(e);
    items_queued++;
  endtask

  // all ops taken, all results seen, then a short pause for any op without a result
  task automatic settle();
    while (items_taken != items_queued || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_runs_in_use(input logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    runs_setting = value;
  endtask

  task automatic queue_random_phase(input logic [CFG_W-1:0] setting, input int count);
    int unsigned          live;
    int unsigned          pick;
    logic [RUN_IDX_W-1:0] ri;
    logic [KEY_W-1:0]     k;
    live = (setting == 0) ? 1 : (setting > RUNS) ? RUNS : setting;
    settle();
    write_runs_in_use(setting);
    repeat (count) begin
      pick = $urandom_range(0, 99);
      ri = RUN_IDX_W'($urandom_range(0, live - 1));
      if (pick < 50) begin
        k = (run_key_floor[ri] > KEY_MAX - 3) ? KEY_MAX
                                             : run_key_floor[ri] + KEY_W'($urandom_range(0, 3));
        run_key_floor[ri] = k;
        queue_op(OP_APPEND, ri, k, TAG_W'($urandom));
      end else if (pick < 82) begin
        queue_op(OP_POP, RUN_IDX_W'($urandom), KEY_W'($urandom), TAG_W'($urandom));
      end else if (pick < 85) begin
        foreach (run_key_floor[r])
          run_key_floor[r] = ($urandom_range(0, 3) == 0) ? KEY_W'($urandom)
                                                         : KEY_W'($urandom_range(0, 15));
        queue_op(OP_CLEAR, RUN_IDX_W'($urandom), KEY_W'($urandom), TAG_W'($urandom));
      end else if (pick < 88) begin
        queue_op(OP_UNUSED, RUN_IDX_W'($urandom), KEY_W'($urandom), TAG_W'($urandom));
      end else if (pick < 95) begin
        // key below the run's key floor, or zero when the floor is under 4
        k = (run_key_floor[ri] >= 4) ? run_key_floor[ri] - KEY_W'($urandom_range(1, 4)) : '0;
        queue_op(OP_APPEND, ri, k, TAG_W'($urandom));
      end else begin
        ri = RUN_IDX_W'($urandom_range(0, 7));
        k = KEY_W'($urandom);
        if (ri < live && k > run_key_floor[ri]) run_key_floor[ri] = k;
        queue_op(OP_APPEND, ri, k, TAG_W'($urandom));
      end
    end
  endtask

  logic [CFG_W-1:0] phase_settings [6] = '{8, 3, 0, 15, 1, 5};

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_table[i]) begin
      if (dir_table[i].kind == ROW_CFG) begin
        settle();
        write_runs_in_use(dir_table[i].cfg);
      end else begin
        queue_op(dir_table[i].op, dir_table[i].ri, dir_table[i].key, dir_table[i].tag,
                 dir_table[i].typed,
                 '{dir_table[i].st, dir_table[i].pk, dir_table[i].pt, dir_table[i].pr});
      end
    end

    for (int p = 0; p < 6; p++)
      queue_random_phase(p == 5 ? CFG_W'($urandom_range(2, 7)) : phase_settings[p], 88);

    settle();
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
